// ===== src/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

  localparam int TIMER_BITS_DEF = 10;
  localparam int BITS_PER_BYTE  = 8;
  localparam int REG_BITS       = 10;
  localparam int NUM_REGS       = 8;
  localparam int APB_ADDR_BITS  = 5;
  localparam int APB_DATA_BITS  = 32;

  typedef logic [REG_BITS-1:0] reg_val_t;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_WRITE_ONE_LOW = 3'd3,
    REG_WRITE_ZERO_LOW = 3'd4,
    REG_WRITE_SLOT    = 3'd5,
    REG_READ_SAMPLE   = 3'd6,
    REG_READ_TAIL     = 3'd7
  } reg_idx_t;

  localparam reg_val_t RST_RESET_LOW      = 10'd480;
  localparam reg_val_t RST_PRESENCE_WAIT  = 10'd70;
  localparam reg_val_t RST_RESET_TAIL     = 10'd410;
  localparam reg_val_t RST_WRITE_ONE_LOW  = 10'd1;
  localparam reg_val_t RST_WRITE_ZERO_LOW = 10'd60;
  localparam reg_val_t RST_WRITE_SLOT     = 10'd61;
  localparam reg_val_t RST_READ_SAMPLE    = 10'd14;
  localparam reg_val_t RST_READ_TAIL      = 10'd45;

  typedef struct packed {
    reg_val_t reset_low_us;
    reg_val_t presence_wait_us;
    reg_val_t reset_tail_us;
    reg_val_t write_one_low_us;
    reg_val_t write_zero_low_us;
    reg_val_t write_slot_us;
    reg_val_t read_sample_wait_us;
    reg_val_t read_tail_us;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       ignored;
  } res_t;

endpackage

// ===== src/owb_if.sv =====
// ----------------------------------------------------------------------------
// owb_in_if / owb_out_if
// Valid/ready channels for tick requests and per-tick bus results.
// ----------------------------------------------------------------------------
interface owb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       line_level;

  modport source (output valid, cmd, data_byte, line_level, input ready);
  modport sink   (input valid, cmd, data_byte, line_level, output ready);
endinterface

interface owb_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_byte;
  logic       ignored;

  modport source (output valid, drive_low, busy_res, done_res, presence, read_byte, ignored,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, read_byte, ignored,
                  output ready);
endinterface

// ===== src/owb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// owb_cfg_regs
// APB register file holding the bus timing values.
// ----------------------------------------------------------------------------
module owb_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [owb_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [owb_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [owb_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                  pready,
  output owb_pkg::cfg_t                         cfg
);

  owb_pkg::cfg_t     cfg_r;
  owb_pkg::reg_idx_t idx;
  owb_pkg::reg_val_t wval;
  owb_pkg::reg_val_t rval;
  logic              wr_en;

  assign idx    = owb_pkg::reg_idx_t'(paddr[4:2]);
  assign wval   = pwdata[owb_pkg::REG_BITS-1:0];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us        <= owb_pkg::RST_RESET_LOW;
      cfg_r.presence_wait_us    <= owb_pkg::RST_PRESENCE_WAIT;
      cfg_r.reset_tail_us       <= owb_pkg::RST_RESET_TAIL;
      cfg_r.write_one_low_us    <= owb_pkg::RST_WRITE_ONE_LOW;
      cfg_r.write_zero_low_us   <= owb_pkg::RST_WRITE_ZERO_LOW;
      cfg_r.write_slot_us       <= owb_pkg::RST_WRITE_SLOT;
      cfg_r.read_sample_wait_us <= owb_pkg::RST_READ_SAMPLE;
      cfg_r.read_tail_us        <= owb_pkg::RST_READ_TAIL;
    end else if (wr_en) begin
      unique case (idx)
        owb_pkg::REG_RESET_LOW:      cfg_r.reset_low_us        <= wval;
        owb_pkg::REG_PRESENCE_WAIT:  cfg_r.presence_wait_us    <= wval;
        owb_pkg::REG_RESET_TAIL:     cfg_r.reset_tail_us       <= wval;
        owb_pkg::REG_WRITE_ONE_LOW:  cfg_r.write_one_low_us    <= wval;
        owb_pkg::REG_WRITE_ZERO_LOW: cfg_r.write_zero_low_us   <= wval;
        owb_pkg::REG_WRITE_SLOT:     cfg_r.write_slot_us       <= wval;
        owb_pkg::REG_READ_SAMPLE:    cfg_r.read_sample_wait_us <= wval;
        owb_pkg::REG_READ_TAIL:      cfg_r.read_tail_us        <= wval;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      owb_pkg::REG_RESET_LOW:      rval = cfg_r.reset_low_us;
      owb_pkg::REG_PRESENCE_WAIT:  rval = cfg_r.presence_wait_us;
      owb_pkg::REG_RESET_TAIL:     rval = cfg_r.reset_tail_us;
      owb_pkg::REG_WRITE_ONE_LOW:  rval = cfg_r.write_one_low_us;
      owb_pkg::REG_WRITE_ZERO_LOW: rval = cfg_r.write_zero_low_us;
      owb_pkg::REG_WRITE_SLOT:     rval = cfg_r.write_slot_us;
      owb_pkg::REG_READ_SAMPLE:    rval = cfg_r.read_sample_wait_us;
      owb_pkg::REG_READ_TAIL:      rval = cfg_r.read_tail_us;
    endcase
  end

  assign prdata = {{(owb_pkg::APB_DATA_BITS-owb_pkg::REG_BITS){1'b0}}, rval};
  assign cfg    = cfg_r;

endmodule

// ===== src/owb_engine.sv =====
// ----------------------------------------------------------------------------
// owb_engine
// Bus sequencer: advances the slot state by one tick per accepted request and
// forms that tick's result.
// ----------------------------------------------------------------------------
module owb_engine #(
  parameter int TIMER_BITS = owb_pkg::TIMER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [1:0]    cmd,
  input  logic [7:0]    data_byte,
  input  logic          line_level,
  input  owb_pkg::cfg_t cfg,
  output owb_pkg::res_t res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_MID  = 2'd2,
    PH_TAIL = 2'd3
  } phase_t;

  typedef logic [TIMER_BITS-1:0] tmr_t;

  phase_t        phase_r, phase_nxt;
  owb_pkg::cmd_t op_r, op_nxt;
  tmr_t          timer_r, timer_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          pres_r, pres_nxt;
  logic [7:0]    rdata_r, rdata_nxt;

  function automatic tmr_t at_least_one(input owb_pkg::reg_val_t v);
    tmr_t m;
    m = tmr_t'(v);
    return (m == '0) ? tmr_t'(1) : m;
  endfunction

  always_comb begin
    owb_pkg::cmd_t c;
    tmr_t          len;
    tmr_t          wlow;
    tmr_t          slot;
    logic          ign;
    logic          busy;
    logic          drive;
    logic          done;
    c         = owb_pkg::cmd_t'(cmd);
    phase_nxt = phase_r;
    op_nxt    = op_r;
    timer_nxt = timer_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    rdata_nxt = rdata_r;
    ign       = 1'b0;
    busy      = 1'b0;
    drive     = 1'b0;
    done      = 1'b0;
    len       = tmr_t'(1);

    if (phase_r == PH_IDLE) begin
      if (c != owb_pkg::CMD_NOP) begin
        op_nxt    = c;
        phase_nxt = PH_LOW;
        timer_nxt = '0;
        bit_nxt   = '0;
        shift_nxt = (c == owb_pkg::CMD_WRITE) ? data_byte : 8'd0;
      end
    end else if (c != owb_pkg::CMD_NOP) begin
      ign = 1'b1;
    end

    if (phase_nxt != PH_IDLE) begin
      busy  = 1'b1;
      drive = (phase_nxt == PH_LOW);
      if (phase_nxt == PH_TAIL && timer_nxt == '0) begin
        if (op_nxt == owb_pkg::CMD_RESET) begin
          pres_nxt = !line_level;
        end else if (op_nxt == owb_pkg::CMD_READ) begin
          shift_nxt[bit_nxt] = shift_nxt[bit_nxt] | line_level;
        end
      end

      wlow = shift_nxt[bit_nxt] ? tmr_t'(cfg.write_one_low_us)
                                : tmr_t'(cfg.write_zero_low_us);
      slot = tmr_t'(cfg.write_slot_us);
      unique case (op_nxt)
        owb_pkg::CMD_RESET: begin
          unique case (phase_nxt)
            PH_LOW:  len = at_least_one(cfg.reset_low_us);
            PH_MID:  len = at_least_one(cfg.presence_wait_us);
            default: len = at_least_one(cfg.reset_tail_us);
          endcase
        end
        owb_pkg::CMD_WRITE: begin
          if (phase_nxt == PH_LOW) begin
            len = (wlow == '0) ? tmr_t'(1) : wlow;
          end else begin
            len = (slot > wlow) ? tmr_t'(slot - wlow) : tmr_t'(1);
          end
        end
        default: begin
          unique case (phase_nxt)
            PH_LOW:  len = at_least_one(cfg.write_one_low_us);
            PH_MID:  len = at_least_one(cfg.read_sample_wait_us);
            default: len = at_least_one(cfg.read_tail_us);
          endcase
        end
      endcase

      if ({1'b0, timer_nxt} + (TIMER_BITS+1)'(1) >= {1'b0, len}) begin
        timer_nxt = '0;
        priority if (phase_nxt == PH_LOW) begin
          phase_nxt = PH_MID;
        end else if (phase_nxt == PH_MID && op_nxt != owb_pkg::CMD_WRITE) begin
          phase_nxt = PH_TAIL;
        end else if (op_nxt == owb_pkg::CMD_RESET ||
                     bit_nxt == 3'(owb_pkg::BITS_PER_BYTE - 1)) begin
          done = 1'b1;
          if (op_nxt == owb_pkg::CMD_READ) begin
            rdata_nxt = shift_nxt;
          end
          phase_nxt = PH_IDLE;
          op_nxt    = owb_pkg::CMD_NOP;
          bit_nxt   = '0;
        end else begin
          bit_nxt   = bit_nxt + 3'd1;
          phase_nxt = PH_LOW;
        end
      end else begin
        timer_nxt = timer_nxt + tmr_t'(1);
      end
    end

    res.drive_low = drive;
    res.busy_res  = busy;
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_byte = rdata_nxt;
    res.ignored   = ign;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= owb_pkg::CMD_NOP;
      timer_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
      rdata_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      timer_r <= timer_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      rdata_r <= rdata_nxt;
    end
  end

endmodule

// ===== src/owb_outbuf.sv =====
// ----------------------------------------------------------------------------
// owb_outbuf
// Result register with a skid entry, so requests keep flowing while a result
// waits.
// ----------------------------------------------------------------------------
module owb_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  owb_pkg::res_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  input  logic          pop_ready,
  output owb_pkg::res_t pop_data
);

  owb_pkg::res_t main_r;
  owb_pkg::res_t skid_r;
  logic          main_vld_r;
  logic          skid_vld_r;
  logic          pop;

  assign pop        = main_vld_r && pop_ready;
  assign push_ready = !skid_vld_r;
  assign pop_valid  = main_vld_r;
  assign pop_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        main_r     <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (push && (!main_vld_r || pop)) begin
      main_r     <= push_data;
      main_vld_r <= 1'b1;
    end else if (push) begin
      skid_r     <= push_data;
      skid_vld_r <= 1'b1;
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

endmodule

// ===== src/onewire_bus_master_top.sv =====
// ----------------------------------------------------------------------------
// onewire_bus_master_top
// 1-Wire bus master: reset/presence, byte write and byte read, one request
// per microsecond tick.
//
//   channel  dir  handshake          content
//   in_ch    in   valid/ready        cmd, data_byte, line_level
//   out_ch   out  valid/ready        drive_low, busy_res, done_res, presence,
//                                    read_byte, ignored
//   APB      in   psel/penable       eight 10-bit timing registers
//
// One request per cycle while in_ch.ready is high; each accepted request's result is registered in the result buffer.
// The sequencer state and the result register bound the path; no multi-cycle
// units.
// A two-entry result buffer keeps in_ch.ready high while out_ch stalls with one entry
// full; ready drops only when both entries are full.
// Synchronous active-low reset returns registers to their defaults and the
// sequencer to idle.
// ----------------------------------------------------------------------------
module onewire_bus_master_top #(
  parameter int TIMER_BITS = owb_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  owb_in_if.sink                            in_ch,
  owb_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [owb_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [owb_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [owb_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  owb_pkg::cfg_t cfg;
  owb_pkg::res_t res;
  owb_pkg::res_t out_res;
  logic          accept;
  logic          buf_ready;

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid && buf_ready;

  owb_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owb_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (in_ch.cmd),
    .data_byte  (in_ch.data_byte),
    .line_level (in_ch.line_level),
    .cfg        (cfg),
    .res        (res)
  );

  owb_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (buf_ready),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (out_res)
  );

  assign out_ch.drive_low = out_res.drive_low;
  assign out_ch.busy_res  = out_res.busy_res;
  assign out_ch.done_res  = out_res.done_res;
  assign out_ch.presence  = out_res.presence;
  assign out_ch.read_byte = out_res.read_byte;
  assign out_ch.ignored   = out_res.ignored;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty result buffer");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !out_ch.valid) |=> out_ch.valid)
    else $error("accepted request produced no result");

  a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.done_res || out_ch.drive_low || out_ch.ignored))
      |-> out_ch.busy_res)
    else $error("done, drive or ignored flagged outside an operation");

endmodule
